FILE: hdl/two_page_flash_eeprom_emulator_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the two-page flash EEPROM emulator
// Shared property forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef TWO_PAGE_FLASH_EEPROM_EMULATOR_MACROS_SVH
`define TWO_PAGE_FLASH_EEPROM_EMULATOR_MACROS_SVH

// same-cycle implication, quiet during reset
`define FEE_ASSERT_SAME(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// next-cycle implication, quiet during reset
`define FEE_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

FILE: hdl/fee_pkg.sv
// ----------------------------------------------------------------------------
// fee_pkg
// Types, codes and defaults for the two-page flash EEPROM emulator.
// ----------------------------------------------------------------------------
`default_nettype none

package fee_pkg;

    localparam int PAGE_WORDS_DEF    = 256;
    localparam int MAX_VARIABLES_DEF = 64;

    localparam logic [31:0] PG_ERASED    = 32'hFFFF_FFFF;
    localparam logic [31:0] PG_RECEIVING = 32'hEEEE_EEEE;
    localparam logic [31:0] PG_ACTIVE    = 32'h0000_0000;

    typedef enum logic [1:0] {
        OP_READ   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_INIT   = 2'd2,
        OP_FORMAT = 2'd3
    } fee_op_t;

    typedef enum logic [2:0] {
        STS_OK        = 3'd0,
        STS_NOT_FOUND = 3'd1,
        STS_BAD_ADDR  = 3'd2,
        STS_NO_PAGE   = 3'd3,
        STS_FULL      = 3'd4
    } fee_status_t;

    typedef enum logic [1:0] {
        SK_READ,
        SK_WRITE,
        SK_XFER,
        SK_RETRY
    } fee_scan_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_STAT0,
        S_STAT1,
        S_DISPATCH,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SCAN_END,
        S_WR_REC,
        S_ERASE,
        S_FMT_MARK,
        S_XF_START,
        S_XF_NEXT,
        S_XF_RMW_RD,
        S_XF_RMW_WR,
        S_XF_FINISH,
        S_DONE
    } fee_state_t;

endpackage

`default_nettype wire

FILE: hdl/fee_req_if.sv
// ----------------------------------------------------------------------------
// fee_req_if
// Request channel: operation, variable address and write value.
// ----------------------------------------------------------------------------
`default_nettype none

interface fee_req_if;
    logic          valid;
    logic          ready;
    logic [1:0]    operation;
    logic [15:0]   virt_addr;
    logic [15:0]   write_data;

    modport source (output valid, output operation, output virt_addr,
                    output write_data, input ready);
    modport sink   (input valid, input operation, input virt_addr,
                    input write_data, output ready);
endinterface

interface fee_rsp_if;
    logic          valid;
    logic          ready;
    logic [2:0]    status;
    logic [15:0]   read_data;

    modport source (output valid, output status, output read_data, input ready);
    modport sink   (input valid, input status, input read_data, output ready);
endinterface

`default_nettype wire

FILE: hdl/fee_ram.sv
// ----------------------------------------------------------------------------
// fee_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module fee_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: hdl/two_page_flash_eeprom_emulator.sv
// ----------------------------------------------------------------------------
// two_page_flash_eeprom_emulator
// 16-bit variables emulated as appended records on two flash-like pages.
// ----------------------------------------------------------------------------
// One request transaction gives one response transaction. All state sits in
// a single RAM of 2*PAGE_WORDS 32-bit words with one write and one registered
// read port; a sequencer walks it one word at a time. After reset the block
// runs a clearing pass over all 2*PAGE_WORDS words (all erased) and accepts
// no request until it ends. A bad-address read or write is answered with no
// RAM access; read and write fetch both page status words and then scan the
// n records of the active page (n <= PAGE_WORDS-1). A write into a full page
// adds an erase of the other page (skipped if it is already erased), then up
// to MAX_VARIABLES scans of the source page, each found variable copied to
// the other page, an erase of the source and one more scan. Format erases
// both pages, then marks page 0 active. Programming of copied records is a
// read-modify-write (AND into the stored word), so a resumed transfer keeps
// flash semantics. A finished response waits in an output register; the
// next request is taken once the sequencer is idle again.
// ----------------------------------------------------------------------------
`default_nettype none

module two_page_flash_eeprom_emulator #(
    parameter int PAGE_WORDS    = fee_pkg::PAGE_WORDS_DEF,
    parameter int MAX_VARIABLES = fee_pkg::MAX_VARIABLES_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    fee_req_if.sink  req,
    fee_rsp_if.source rsp
);

    localparam int IDX_W  = $clog2(PAGE_WORDS);
    localparam int ADDR_W = $clog2(2 * PAGE_WORDS);
    localparam int CUR_W  = $clog2(PAGE_WORDS + 1);
    localparam int VA_W   = 17;

    localparam logic [ADDR_W-1:0] PAGE_BASE = ADDR_W'(PAGE_WORDS);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(2 * PAGE_WORDS - 1);
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(PAGE_WORDS - 1);
    localparam logic [IDX_W-1:0]  FIRST_IDX = IDX_W'(1);

    // word address of slot idx on page pg
    function automatic logic [ADDR_W-1:0] addr_of(input logic pg,
                                                  input logic [IDX_W-1:0] idx);
        logic [ADDR_W-1:0] base;
        base = pg ? PAGE_BASE : '0;
        return base + ADDR_W'(idx);
    endfunction

    // sequencer
    fee_pkg::fee_state_t state_reg, state_next, ret_reg, ret_next;

    // latched request
    fee_pkg::fee_op_t  op_reg, op_next;
    logic [15:0]       va_reg, va_next;
    logic [15:0]       wd_reg, wd_next;
    logic [31:0]       s0_reg, s0_next;
    logic [31:0]       s1_reg, s1_next;

    // page scan
    fee_pkg::fee_scan_t scan_kind_reg, scan_kind_next;
    logic               scan_page_reg, scan_page_next;
    logic [IDX_W-1:0]   scan_idx_reg, scan_idx_next;
    logic [15:0]        scan_va_reg, scan_va_next;
    logic               hit_reg, hit_next;
    logic [15:0]        hit_data_reg, hit_data_next;
    logic               slot_found_reg, slot_found_next;
    logic [IDX_W-1:0]   slot_reg, slot_next;

    // page transfer
    logic               xf_src_reg, xf_src_next;
    logic               xf_init_reg, xf_init_next;
    logic [VA_W-1:0]    xf_va_reg, xf_va_next;
    logic [CUR_W-1:0]   cursor_reg, cursor_next;

    // erase sweep
    logic [ADDR_W-1:0]  erase_addr_reg, erase_addr_next;
    logic [ADDR_W-1:0]  erase_end_reg, erase_end_next;

    // result
    fee_pkg::fee_status_t res_status_reg, res_status_next;
    logic [15:0]          res_data_reg, res_data_next;
    logic                 out_valid_reg, out_valid_next;
    logic [2:0]           out_status_reg, out_status_next;
    logic [15:0]          out_data_reg, out_data_next;

    // RAM port
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [31:0]       mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic [31:0]       mem_rdata;

    logic req_fire;
    logic out_load;
    logic dst_page;

    assign req_fire = req.valid && req.ready;
    assign out_load = (state_reg == fee_pkg::S_DONE) && (!out_valid_reg || rsp.ready);
    assign dst_page = ~xf_src_reg;

    fee_ram #(
        .WIDTH (32),
        .DEPTH (2 * PAGE_WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // ---------------- next state and datapath ----------------
    always_comb
    begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        op_next         = op_reg;
        va_next         = va_reg;
        wd_next         = wd_reg;
        s0_next         = s0_reg;
        s1_next         = s1_reg;
        scan_kind_next  = scan_kind_reg;
        scan_page_next  = scan_page_reg;
        scan_idx_next   = scan_idx_reg;
        scan_va_next    = scan_va_reg;
        hit_next        = hit_reg;
        hit_data_next   = hit_data_reg;
        slot_found_next = slot_found_reg;
        slot_next       = slot_reg;
        xf_src_next     = xf_src_reg;
        xf_init_next    = xf_init_reg;
        xf_va_next      = xf_va_reg;
        cursor_next     = cursor_reg;
        erase_addr_next = erase_addr_reg;
        erase_end_next  = erase_end_reg;
        res_status_next = res_status_reg;
        res_data_next   = res_data_reg;

        unique case (state_reg)
            fee_pkg::S_IDLE:
            begin
                if (req_fire)
                begin
                    op_next         = fee_pkg::fee_op_t'(req.operation);
                    va_next         = req.virt_addr;
                    wd_next         = req.write_data;
                    res_status_next = fee_pkg::STS_OK;
                    res_data_next   = '0;
                    if ((fee_pkg::fee_op_t'(req.operation) == fee_pkg::OP_READ ||
                         fee_pkg::fee_op_t'(req.operation) == fee_pkg::OP_WRITE) &&
                        (req.virt_addr == 16'd0 ||
                         32'(req.virt_addr) > 32'(MAX_VARIABLES)))
                    begin
                        res_status_next = fee_pkg::STS_BAD_ADDR;
                        state_next      = fee_pkg::S_DONE;
                    end
                    else
                    begin
                        state_next = fee_pkg::S_STAT0;
                    end
                end
            end

            fee_pkg::S_STAT0:
                state_next = fee_pkg::S_STAT1;

            fee_pkg::S_STAT1:
            begin
                s0_next    = mem_rdata;
                state_next = fee_pkg::S_DISPATCH;
            end

            fee_pkg::S_DISPATCH:
            begin
                s1_next         = mem_rdata;
                scan_idx_next   = FIRST_IDX;
                scan_va_next    = va_reg;
                hit_next        = 1'b0;
                slot_found_next = 1'b0;
                unique case (op_reg)
                    fee_pkg::OP_READ, fee_pkg::OP_WRITE:
                    begin
                        scan_kind_next = (op_reg == fee_pkg::OP_READ) ?
                                         fee_pkg::SK_READ : fee_pkg::SK_WRITE;
                        if (s0_reg == fee_pkg::PG_ACTIVE)
                        begin
                            scan_page_next = 1'b0;
                            state_next     = fee_pkg::S_SCAN_RD;
                        end
                        else if (mem_rdata == fee_pkg::PG_ACTIVE)
                        begin
                            scan_page_next = 1'b1;
                            state_next     = fee_pkg::S_SCAN_RD;
                        end
                        else
                        begin
                            res_status_next = fee_pkg::STS_NO_PAGE;
                            state_next      = fee_pkg::S_DONE;
                        end
                    end
                    fee_pkg::OP_INIT:
                    begin
                        if ((s0_reg == fee_pkg::PG_ACTIVE && mem_rdata == fee_pkg::PG_ERASED) ||
                            (mem_rdata == fee_pkg::PG_ACTIVE && s0_reg == fee_pkg::PG_ERASED))
                        begin
                            state_next = fee_pkg::S_DONE;
                        end
                        else if (s0_reg == fee_pkg::PG_ACTIVE &&
                                 mem_rdata == fee_pkg::PG_RECEIVING)
                        begin
                            xf_src_next  = 1'b0;
                            xf_init_next = 1'b1;
                            state_next   = fee_pkg::S_XF_START;
                        end
                        else if (mem_rdata == fee_pkg::PG_ACTIVE &&
                                 s0_reg == fee_pkg::PG_RECEIVING)
                        begin
                            xf_src_next  = 1'b1;
                            xf_init_next = 1'b1;
                            state_next   = fee_pkg::S_XF_START;
                        end
                        else
                        begin
                            erase_addr_next = '0;
                            erase_end_next  = LAST_ADDR;
                            ret_next        = fee_pkg::S_FMT_MARK;
                            state_next      = fee_pkg::S_ERASE;
                        end
                    end
                    fee_pkg::OP_FORMAT:
                    begin
                        erase_addr_next = '0;
                        erase_end_next  = LAST_ADDR;
                        ret_next        = fee_pkg::S_FMT_MARK;
                        state_next      = fee_pkg::S_ERASE;
                    end
                    default:
                        state_next = fee_pkg::S_DONE;
                endcase
            end

            fee_pkg::S_SCAN_RD:
                state_next = fee_pkg::S_SCAN_CHK;

            fee_pkg::S_SCAN_CHK:
            begin
                if (mem_rdata == fee_pkg::PG_ERASED)
                begin
                    // blank word ends the record list
                    slot_found_next = 1'b1;
                    slot_next       = scan_idx_reg;
                    state_next      = fee_pkg::S_SCAN_END;
                end
                else
                begin
                    if (mem_rdata[31:16] == scan_va_reg)
                    begin
                        hit_next      = 1'b1;
                        hit_data_next = mem_rdata[15:0];
                    end
                    if (scan_idx_reg == LAST_IDX)
                    begin
                        state_next = fee_pkg::S_SCAN_END;
                    end
                    else
                    begin
                        scan_idx_next = scan_idx_reg + IDX_W'(1);
                        state_next    = fee_pkg::S_SCAN_RD;
                    end
                end
            end

            fee_pkg::S_SCAN_END:
            begin
                case (scan_kind_reg)
                    fee_pkg::SK_READ:
                    begin
                        res_status_next = hit_reg ? fee_pkg::STS_OK : fee_pkg::STS_NOT_FOUND;
                        res_data_next   = hit_reg ? hit_data_reg : 16'd0;
                        state_next      = fee_pkg::S_DONE;
                    end
                    fee_pkg::SK_WRITE:
                    begin
                        if (slot_found_reg)
                        begin
                            state_next = fee_pkg::S_WR_REC;
                        end
                        else
                        begin
                            xf_src_next  = scan_page_reg;
                            xf_init_next = 1'b0;
                            if ((scan_page_reg ? s0_reg : s1_reg) != fee_pkg::PG_ERASED)
                            begin
                                erase_addr_next = addr_of(~scan_page_reg, '0);
                                erase_end_next  = addr_of(~scan_page_reg, LAST_IDX);
                                ret_next        = fee_pkg::S_XF_START;
                                state_next      = fee_pkg::S_ERASE;
                            end
                            else
                            begin
                                state_next = fee_pkg::S_XF_START;
                            end
                        end
                    end
                    fee_pkg::SK_XFER:
                    begin
                        if (hit_reg)
                        begin
                            state_next = fee_pkg::S_XF_RMW_RD;
                        end
                        else
                        begin
                            xf_va_next = xf_va_reg + VA_W'(1);
                            state_next = fee_pkg::S_XF_NEXT;
                        end
                    end
                    default:
                    begin
                        // retry of the write on the fresh page
                        if (slot_found_reg)
                        begin
                            state_next = fee_pkg::S_WR_REC;
                        end
                        else
                        begin
                            res_status_next = fee_pkg::STS_FULL;
                            state_next      = fee_pkg::S_DONE;
                        end
                    end
                endcase
            end

            fee_pkg::S_WR_REC:
                state_next = fee_pkg::S_DONE;

            fee_pkg::S_ERASE:
            begin
                if (erase_addr_reg == erase_end_reg)
                begin
                    state_next = ret_reg;
                end
                else
                begin
                    erase_addr_next = erase_addr_reg + ADDR_W'(1);
                end
            end

            fee_pkg::S_FMT_MARK:
                state_next = fee_pkg::S_DONE;

            fee_pkg::S_XF_START:
            begin
                cursor_next = CUR_W'(1);
                xf_va_next  = VA_W'(1);
                state_next  = fee_pkg::S_XF_NEXT;
            end

            fee_pkg::S_XF_NEXT:
            begin
                if (32'(xf_va_reg) > 32'(MAX_VARIABLES) ||
                    32'(cursor_reg) >= 32'(PAGE_WORDS))
                begin
                    state_next = fee_pkg::S_XF_FINISH;
                end
                else
                begin
                    scan_kind_next  = fee_pkg::SK_XFER;
                    scan_page_next  = xf_src_reg;
                    scan_idx_next   = FIRST_IDX;
                    scan_va_next    = xf_va_reg[15:0];
                    hit_next        = 1'b0;
                    slot_found_next = 1'b0;
                    state_next      = fee_pkg::S_SCAN_RD;
                end
            end

            fee_pkg::S_XF_RMW_RD:
                state_next = fee_pkg::S_XF_RMW_WR;

            fee_pkg::S_XF_RMW_WR:
            begin
                cursor_next = cursor_reg + CUR_W'(1);
                xf_va_next  = xf_va_reg + VA_W'(1);
                state_next  = fee_pkg::S_XF_NEXT;
            end

            fee_pkg::S_XF_FINISH:
            begin
                erase_addr_next = addr_of(xf_src_reg, '0);
                erase_end_next  = addr_of(xf_src_reg, LAST_IDX);
                ret_next        = xf_init_reg ? fee_pkg::S_DONE : fee_pkg::S_SCAN_RD;
                scan_kind_next  = fee_pkg::SK_RETRY;
                scan_page_next  = dst_page;
                scan_idx_next   = FIRST_IDX;
                scan_va_next    = va_reg;
                hit_next        = 1'b0;
                slot_found_next = 1'b0;
                state_next      = fee_pkg::S_ERASE;
            end

            fee_pkg::S_DONE:
            begin
                if (out_load)
                begin
                    state_next = fee_pkg::S_IDLE;
                end
            end

            default:
                state_next = fee_pkg::S_IDLE;
        endcase
    end

    // ---------------- RAM control and handshake ----------------
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = fee_pkg::PG_ERASED;
        mem_raddr = '0;
        req.ready = (state_reg == fee_pkg::S_IDLE);

        unique case (state_reg)
            fee_pkg::S_STAT0:
                mem_raddr = '0;
            fee_pkg::S_STAT1:
                mem_raddr = PAGE_BASE;
            fee_pkg::S_SCAN_RD:
                mem_raddr = addr_of(scan_page_reg, scan_idx_reg);
            fee_pkg::S_WR_REC:
            begin
                // target slot is blank, so the AND is the record itself
                mem_we    = 1'b1;
                mem_waddr = addr_of(scan_page_reg, slot_reg);
                mem_wdata = {va_reg, wd_reg};
            end
            fee_pkg::S_ERASE:
            begin
                mem_we    = 1'b1;
                mem_waddr = erase_addr_reg;
                mem_wdata = fee_pkg::PG_ERASED;
            end
            fee_pkg::S_FMT_MARK:
            begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = fee_pkg::PG_ACTIVE;
            end
            fee_pkg::S_XF_START:
            begin
                // status is erased or already receiving
                mem_we    = 1'b1;
                mem_waddr = addr_of(dst_page, '0);
                mem_wdata = fee_pkg::PG_RECEIVING;
            end
            fee_pkg::S_XF_RMW_RD:
                mem_raddr = addr_of(dst_page, cursor_reg[IDX_W-1:0]);
            fee_pkg::S_XF_RMW_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = addr_of(dst_page, cursor_reg[IDX_W-1:0]);
                mem_wdata = mem_rdata & {xf_va_reg[15:0], hit_data_reg};
            end
            fee_pkg::S_XF_FINISH:
            begin
                mem_we    = 1'b1;
                mem_waddr = addr_of(dst_page, '0);
                mem_wdata = fee_pkg::PG_ACTIVE;
            end
            default:
                mem_we = 1'b0;
        endcase
    end

    // ---------------- output register ----------------
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;
        if (out_load)
        begin
            out_valid_next  = 1'b1;
            out_status_next = res_status_reg;
            out_data_next   = res_data_reg;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.read_data = out_data_reg;

    // control state; reset starts the clearing pass over both pages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= fee_pkg::S_ERASE;
            ret_reg        <= fee_pkg::S_IDLE;
            erase_addr_reg <= '0;
            erase_end_reg  <= LAST_ADDR;
            cursor_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            erase_addr_reg <= erase_addr_next;
            erase_end_reg  <= erase_end_next;
            cursor_reg     <= cursor_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        va_reg         <= va_next;
        wd_reg         <= wd_next;
        s0_reg         <= s0_next;
        s1_reg         <= s1_next;
        scan_kind_reg  <= scan_kind_next;
        scan_page_reg  <= scan_page_next;
        scan_idx_reg   <= scan_idx_next;
        scan_va_reg    <= scan_va_next;
        hit_reg        <= hit_next;
        hit_data_reg   <= hit_data_next;
        slot_found_reg <= slot_found_next;
        slot_reg       <= slot_next;
        xf_src_reg     <= xf_src_next;
        xf_init_reg    <= xf_init_next;
        xf_va_reg      <= xf_va_next;
        res_status_reg <= res_status_next;
        res_data_reg   <= res_data_next;
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
    end

endmodule

`default_nettype wire

FILE: hdl/fee_checker.sv
// ----------------------------------------------------------------------------
// fee_checker
// Port-level checks on the response channel of the emulator.
// ----------------------------------------------------------------------------
`default_nettype none

`include "two_page_flash_eeprom_emulator_macros.svh"

module fee_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        rsp_valid,
    input wire logic        rsp_ready,
    input wire logic [2:0]  rsp_status,
    input wire logic [15:0] rsp_read_data
);

    logic stalled;
    logic data_nonzero;
    logic status_ok;
    assign stalled      = rsp_valid && !rsp_ready;
    assign data_nonzero = rsp_valid && (rsp_read_data != 16'd0);
    assign status_ok    = (rsp_status == 3'(fee_pkg::STS_OK));

    `FEE_ASSERT_NEXT(a_rsp_hold, clk, rst_n, stalled, rsp_valid)
    `FEE_ASSERT_NEXT(a_rsp_stable, clk, rst_n, stalled, $stable(rsp_status) && $stable(rsp_read_data))
    `FEE_ASSERT_SAME(a_status_range, clk, rst_n, rsp_valid, rsp_status <= 3'(fee_pkg::STS_FULL))
    `FEE_ASSERT_SAME(a_data_only_ok, clk, rst_n, data_nonzero, status_ok)

endmodule

bind two_page_flash_eeprom_emulator fee_checker u_fee_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_status    (rsp.status),
    .rsp_read_data (rsp.read_data)
);

`default_nettype wire
